FILE: src/lffsc_pkg.sv
// Package with the shared state type and constants of the segment cache.
package lffsc_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [31:0] CAPACITY_RESET = 32'd1048575;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_HSCAN   = 10'b0000000010,
    ST_PSCAN   = 10'b0000000100,
    ST_ESCAN   = 10'b0000001000,
    ST_SHIFT   = 10'b0000010000,
    ST_EVICT   = 10'b0000100000,
    ST_MERGE   = 10'b0001000000,
    ST_DONE    = 10'b0010000000,
    ST_CLEAR   = 10'b0100000000,
    ST_UPDATE  = 10'b1000000000
  } state_t;

endpackage

FILE: src/lffsc_if.sv
// Valid/ready channel interface carrying one word of payload.
interface lffsc_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lffsc_seg_mem.sv
// Segment table memory: one write port, one registered read port.
module lffsc_seg_mem #(
  parameter int DEPTH = 64,
  parameter int W = 57
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/lru_first_fit_segment_cache.sv
// Top level of the first-fit segment cache with least-recently-used eviction.
//
// Requests arrive as words on the in_ channel (file_id, file_size); each gives
// exactly one result word on the out_ channel (address, hit, failed, used).
// The segment table and the use stamps live in one synchronous memory,
// each row a segment: file flag, id, start, size and stamp.
// One request is handled at a time. A hit costs part of one scan of the table
// (read then test for each segment). A miss costs a full hit scan, a placement
// scan, and for each eviction a scan for the oldest stamp, a row move pass to
// close merged slots and another placement scan; the single memory port sets
// these costs.
// After reset, and after every write of capacity, a clear pass writes the
// single free segment; no request is taken meanwhile.
// The result register holds its word while the receiver stalls; the next
// request is accepted once the result has been taken.
module lru_first_fit_segment_cache
  import lffsc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 20,
  parameter int ID_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lffsc_if.sink                 in_ch,
  lffsc_if.source               out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = IW + 1;
  localparam int RW = 1 + ID_BITS + 2 * ADDR_BITS + 32;

  typedef struct packed {
    logic                 is_file;
    logic [ID_BITS-1:0]   id;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic [31:0]          stamp;
  } row_t;

  state_t state_r, state_nxt;
  logic [ADDR_BITS-1:0] capacity_r;
  logic [CW-1:0] count_r;
  logic [ADDR_BITS-1:0] used_r;
  logic [31:0] clock_r;
  logic [ID_BITS-1:0] id_r;
  logic [ADDR_BITS-1:0] size_r;
  logic [CW-1:0] idx_r;
  logic phase_r;
  logic found_r;
  logic [IW-1:0] vic_r;
  logic [31:0] vstamp_r;
  row_t prev_r;
  logic prev_ok_r;
  logic [2:0] sub_r;
  logic [IW-1:0] tgt_r;
  logic [CW-1:0] shift_dst_r, shift_end_r;
  logic shift_up_r;
  row_t hold_r;
  logic ins_r;
  logic out_valid_r;
  logic [ADDR_BITS-1:0] out_addr_r, out_used_r;
  logic out_hit_r, out_failed_r;

  logic mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  row_t mem_wdata, mem_rdata;
  logic [RW-1:0] rdata_raw;

  lffsc_seg_mem #(.DEPTH(MAX_SEGMENTS), .W(RW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rdata_raw)
  );
  assign mem_rdata = row_t'(rdata_raw);

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_CAPACITY);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CAPACITY) ?
                      CFG_DATA_W'(capacity_r) : '0;

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = {out_addr_r, out_hit_r, out_failed_r, out_used_r};

  logic [IW-1:0] cur;
  assign cur = idx_r[IW-1:0];
  logic last;
  assign last = (idx_r + CW'(1)) >= count_r;

  // Control: reads go out on phase 0, data is tested on phase 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      capacity_r  <= ADDR_BITS'(CAPACITY_RESET);
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      idx_r       <= '0;
      count_r     <= CW'(1);
      used_r      <= '0;
      clock_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        capacity_r <= cfg_pwdata[ADDR_BITS-1:0];
      end
      unique case (state_r)
        ST_CLEAR: begin
          count_r <= CW'(1);
          used_r <= '0;
          clock_r <= '0;
        end
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            id_r <= in_ch.data[ID_BITS+ADDR_BITS-1:ADDR_BITS];
            size_r <= in_ch.data[ADDR_BITS-1:0];
            idx_r <= '0;
            phase_r <= 1'b0;
          end
        end
        ST_HSCAN: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            if (mem_rdata.is_file && mem_rdata.id == id_r) begin
              clock_r <= clock_r + 32'd1;
              out_addr_r <= mem_rdata.start;
              out_hit_r <= 1'b1;
              out_failed_r <= 1'b0;
              out_used_r <= used_r;
              out_valid_r <= 1'b1;
            end else if (last) begin
              idx_r <= '0;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        ST_PSCAN: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            if (!mem_rdata.is_file && (mem_rdata.size == size_r ||
                (mem_rdata.size > size_r && count_r < CW'(MAX_SEGMENTS)))) begin
              clock_r <= clock_r + 32'd1;
              used_r <= used_r + size_r;
              out_addr_r <= mem_rdata.start;
              out_hit_r <= 1'b0;
              out_failed_r <= 1'b0;
              out_used_r <= used_r + size_r;
              tgt_r <= cur;
              hold_r <= mem_rdata;
              ins_r <= (mem_rdata.size != size_r);
            end else if (last) begin
              idx_r <= '0;
              found_r <= 1'b0;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        ST_UPDATE: begin
          if (ins_r) begin
            // Move rows tgt..count-1 up by one, top down, then write the split.
            shift_up_r <= 1'b1;
            shift_dst_r <= count_r;
            shift_end_r <= CW'(tgt_r) + CW'(1);
            count_r <= count_r + CW'(1);
            sub_r <= 3'd0;
          end else begin
            out_valid_r <= 1'b1;
          end
          phase_r <= 1'b0;
        end
        ST_ESCAN: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            if (mem_rdata.is_file && (!found_r || mem_rdata.stamp < vstamp_r)) begin
              found_r <= 1'b1;
              vic_r <= cur;
              vstamp_r <= mem_rdata.stamp;
            end
            if (last) begin
              idx_r <= '0;
              sub_r <= 3'd0;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
            if (last && !(found_r || mem_rdata.is_file)) begin
              out_addr_r <= '0;
              out_hit_r <= 1'b0;
              out_failed_r <= 1'b1;
              out_used_r <= used_r;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_EVICT: begin
          // sub 0: read victim, 1: read next, 2: read prev, 3: decide.
          sub_r <= sub_r + 3'd1;
          if (sub_r == 3'd1) hold_r <= mem_rdata;
          if (sub_r == 3'd2) begin
            prev_r <= mem_rdata;
            prev_ok_r <= (CW'(vic_r) + CW'(1) < count_r);
          end
          if (sub_r == 3'd3) begin
            // prev_r still holds the next row here.
            prev_r <= mem_rdata;
            prev_ok_r <= prev_ok_r && !prev_r.is_file;
            found_r <= (vic_r != '0);
            used_r <= used_r - hold_r.size;
          end
        end
        ST_MERGE: begin
          // hold_r: victim, prev_r: previous row, prev_ok_r: next is free.
          count_r <= count_r - CW'(prev_ok_r) - CW'(found_r && !prev_r.is_file);
          shift_up_r <= 1'b0;
          if (found_r && !prev_r.is_file) begin
            shift_dst_r <= CW'(vic_r);
            shift_end_r <= count_r - CW'(1) - CW'(prev_ok_r);
          end else begin
            shift_dst_r <= CW'(vic_r) + CW'(1);
            shift_end_r <= count_r - CW'(1);
          end
          sub_r <= {2'b00, prev_ok_r};
          phase_r <= 1'b0;
        end
        ST_SHIFT: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            if (shift_up_r) shift_dst_r <= shift_dst_r - CW'(1);
            else shift_dst_r <= shift_dst_r + CW'(1);
          end
        end
        ST_DONE: begin
          if (shift_up_r) out_valid_r <= 1'b1;
          idx_r <= '0;
          phase_r <= 1'b0;
        end
        default: ;
      endcase
      if (state_r == ST_EVICT && sub_r == 3'd3) idx_r <= '0;
    end
  end

  // Merge bookkeeping needs the sizes of neighbours; kept in registers.
  row_t next_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_EVICT && sub_r == 3'd2) next_r <= mem_rdata;
  end

  logic merge_prev;
  assign merge_prev = found_r && !prev_r.is_file;
  logic [ADDR_BITS-1:0] merged_size;
  assign merged_size = hold_r.size + (prev_ok_r ? next_r.size : '0)
                       + (merge_prev ? prev_r.size : '0);

  logic shift_more;
  assign shift_more = shift_up_r ? (shift_dst_r >= shift_end_r)
                                 : (shift_dst_r < shift_end_r);
  logic [CW-1:0] shift_src;
  assign shift_src = shift_up_r ? shift_dst_r - CW'(1) :
                     shift_dst_r + CW'(sub_r[0]) + CW'(merge_prev);

  always_comb begin
    state_nxt = state_r;
    mem_we = 1'b0;
    mem_waddr = cur;
    mem_wdata = mem_rdata;
    mem_raddr = cur;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{is_file: 1'b0, id: '0, start: '0, size: capacity_r, stamp: '0};
        state_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = ST_HSCAN;
      ST_HSCAN: begin
        if (phase_r) begin
          if (mem_rdata.is_file && mem_rdata.id == id_r) begin
            mem_we = 1'b1;
            mem_wdata.stamp = clock_r + 32'd1;
            state_nxt = ST_IDLE;
          end else if (last) begin
            state_nxt = ST_PSCAN;
          end
        end
      end
      ST_PSCAN: begin
        if (phase_r) begin
          if (!mem_rdata.is_file && (mem_rdata.size == size_r ||
              (mem_rdata.size > size_r && count_r < CW'(MAX_SEGMENTS)))) begin
            mem_we = 1'b1;
            mem_wdata = '{is_file: 1'b1, id: id_r, start: mem_rdata.start,
                          size: size_r, stamp: clock_r + 32'd1};
            state_nxt = ST_UPDATE;
          end else if (last) begin
            state_nxt = ST_ESCAN;
          end
        end
      end
      ST_UPDATE: state_nxt = ins_r ? ST_SHIFT : ST_IDLE;
      ST_ESCAN: begin
        if (phase_r && last) begin
          state_nxt = (found_r || mem_rdata.is_file) ? ST_EVICT : ST_IDLE;
        end
      end
      ST_EVICT: begin
        mem_raddr = vic_r;
        if (sub_r == 3'd1) mem_raddr = vic_r + IW'(1);
        if (sub_r == 3'd2) mem_raddr = vic_r - IW'(1);
        if (sub_r == 3'd3) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        mem_we = 1'b1;
        mem_waddr = merge_prev ? vic_r - IW'(1) : vic_r;
        mem_wdata = '{is_file: 1'b0, id: '0,
                      start: merge_prev ? prev_r.start : hold_r.start,
                      size: merged_size, stamp: '0};
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        mem_raddr = shift_src[IW-1:0];
        mem_waddr = shift_dst_r[IW-1:0];
        if (!shift_more) begin
          if (shift_up_r) begin
            mem_we = 1'b1;
            mem_waddr = tgt_r + IW'(1);
            mem_wdata = '{is_file: 1'b0, id: '0, start: hold_r.start + size_r,
                          size: hold_r.size - size_r, stamp: '0};
          end
          state_nxt = ST_DONE;
        end else if (phase_r) begin
          mem_we = 1'b1;
        end
      end
      ST_DONE: state_nxt = shift_up_r ? ST_IDLE : ST_PSCAN;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) state_nxt = ST_CLEAR;
  end

  property p_no_take_while_full;
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> !in_ch.ready;
  endproperty
  assert property (p_no_take_while_full) else $error("request taken while a result word waits");

  property p_count_range;
    @(posedge clk) disable iff (!rst_n) count_r != '0 && count_r <= CW'(MAX_SEGMENTS);
  endproperty
  assert property (p_count_range) else $error("segment count out of range");

  property p_hit_clean;
    @(posedge clk) disable iff (!rst_n) out_valid_r && out_hit_r |-> !out_failed_r;
  endproperty
  assert property (p_hit_clean) else $error("hit and failed together");

  property p_fail_addr;
    @(posedge clk) disable iff (!rst_n) out_valid_r && out_failed_r |-> out_addr_r == '0;
  endproperty
  assert property (p_fail_addr) else $error("failed word carries an address");

  property p_cfg_clear;
    @(posedge clk) disable iff (!rst_n) cfg_wr |=> state_r == ST_CLEAR;
  endproperty
  assert property (p_cfg_clear) else $error("capacity write did not empty store");
endmodule
